@@ src/dnsp_pkg.sv @@
// Shared types and constants for the DNS A-record response parser.
`timescale 1ns / 1ps

package dnsp_pkg;

    localparam int unsigned LABEL_LIMIT = 128;

    localparam logic [15:0] QUERY_ID_RESET    = 16'h4741;
    localparam logic [15:0] SERVER_PORT_RESET = 16'd53;
    localparam logic [15:0] FLAG_RESPONSE     = 16'h8000;
    localparam logic [15:0] FLAG_RCODE        = 16'h000F;
    localparam logic [7:0]  LEN_PTR_MASK      = 8'hC0;
    localparam logic [7:0]  LABEL_MAX         = 8'd63;
    localparam logic [7:0]  LABEL_LIMIT_B     = 8'(LABEL_LIMIT);
    localparam logic [15:0] QDCOUNT_ONE       = 16'd1;
    localparam logic [15:0] TYPE_A            = 16'd1;
    localparam logic [15:0] CLASS_IN          = 16'd1;
    localparam logic [15:0] A_RDLENGTH        = 16'd4;

    localparam logic [3:0] HDR_BYTES       = 4'd12;
    localparam logic [3:0] HDR_KEEP_BYTES  = 4'd8;
    localparam logic [3:0] QFIXED_BYTES    = 4'd4;
    localparam logic [3:0] AFIXED_BYTES    = 4'd10;
    localparam logic [3:0] TTL_FIRST       = 4'd4;
    localparam logic [3:0] TTL_END         = 4'd8;

    localparam logic [0:0] REG_QUERY_ID    = 1'b0;
    localparam logic [0:0] REG_SERVER_PORT = 1'b1;

    typedef enum logic [1:0] {
        OUT_FOUND     = 2'd0,
        OUT_NOADDR    = 2'd1,
        OUT_REJECT    = 2'd2,
        OUT_UNDECIDED = 2'd3
    } outcome_t;

    typedef enum logic [10:0] {
        PH_HEADER = 11'b000_0000_0001,
        PH_QLEN   = 11'b000_0000_0010,
        PH_QLABEL = 11'b000_0000_0100,
        PH_QPTR   = 11'b000_0000_1000,
        PH_QFIXED = 11'b000_0001_0000,
        PH_ALEN   = 11'b000_0010_0000,
        PH_ALABEL = 11'b000_0100_0000,
        PH_APTR   = 11'b000_1000_0000,
        PH_AFIXED = 11'b001_0000_0000,
        PH_RSKIP  = 11'b010_0000_0000,
        PH_RADDR  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] src_port;
        logic        last_byte;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } result_t;

    typedef struct packed {
        logic [15:0] expected_query_id;
        logic [15:0] server_port;
    } cfg_t;

endpackage

@@ src/dns_response_a_record_parser.sv @@
// Top level of the DNS A-record response parser with its configuration registers.
//
// Usage: the input channel (s_valid/s_ready) carries one UDP payload byte per
// word, with the packet's source port and a last_byte mark on the final word.
// The result channel (m_valid/m_ready) carries one word per packet: status
// (0 address found, 1 no address, 2 rejected) and the IPv4 address when found.
// Configuration: cfg_wr_en with cfg_index 0 writes the expected query id, index 1
// the server port; write only while no packet is in flight.
// Throughput: one payload word per cycle, except that a last word waits while the
// result register is full and m_ready is low, through a single parse step between
// the input register and the result register. The result word is registered in
// the result register, which drives m_valid, once the last word is taken.
// Reset: aresetn low clears both channels, returns the parser to the header
// phase and loads query id 0x4741 and server port 53.
// Stall: while a result waits on m_ready, non-final words keep flowing; a last
// word is held in the input register until the result register frees.
`timescale 1ns / 1ps

module dns_response_a_record_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_src_port,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_address,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);
    import dnsp_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    word_t   s_word;
    word_t   word;
    logic    word_valid;
    logic    take;
    logic    out_ready;
    logic    res_valid;
    result_t res;

    assign s_word.data_byte = s_data_byte;
    assign s_word.src_port  = s_src_port;
    assign s_word.last_byte = s_last_byte;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUERY_ID:    cfg_next.expected_query_id = cfg_wr_data;
                REG_SERVER_PORT: cfg_next.server_port       = cfg_wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_query_id <= QUERY_ID_RESET;
            cfg_reg.server_port       <= SERVER_PORT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dnsp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    dnsp_parse_core u_parse_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .word_valid (word_valid),
        .word       (word),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    dnsp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_address (m_address)
    );

endmodule

@@ src/dnsp_in_stage.sv @@
// Input register stage holding one accepted payload word.
`timescale 1ns / 1ps

module dnsp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dnsp_pkg::word_t s_word,
    input  logic           take,
    output logic           word_valid,
    output dnsp_pkg::word_t word
);
    import dnsp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;

    assign s_ready    = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

@@ src/dnsp_parse_core.sv @@
// Per-byte DNS response parse state and its next-state logic.
`timescale 1ns / 1ps

module dnsp_parse_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  dnsp_pkg::cfg_t    cfg,
    input  logic             word_valid,
    input  dnsp_pkg::word_t   word,
    input  logic             out_ready,
    output logic             take,
    output logic             res_valid,
    output dnsp_pkg::result_t res
);
    import dnsp_pkg::*;

    phase_t      phase_reg,   phase_next;
    outcome_t    outcome_reg, outcome_next, outcome_final;
    logic [3:0]  bif_reg,     bif_next;
    logic [63:0] header_reg,  header_next;
    logic [15:0] answers_reg, answers_next;
    logic [5:0]  lbl_left_reg, lbl_left_next;
    logic [7:0]  lbl_count_reg, lbl_count_next;
    logic [15:0] rec_left_reg, rec_left_next;
    logic [47:0] fixed_reg,   fixed_next;
    logic [31:0] addr_reg,    addr_next;

    logic [7:0]  b;
    logic [15:0] hdr_id, hdr_flags, hdr_qd;
    logic [15:0] ans_dec;
    logic        answer_name;

    assign b           = word.data_byte;
    assign take        = word_valid && (!word.last_byte || out_ready);
    assign res_valid   = take && word.last_byte;
    assign hdr_id      = header_reg[63:48];
    assign hdr_flags   = header_reg[47:32];
    assign hdr_qd      = header_reg[31:16];
    assign ans_dec     = answers_reg - 16'd1;
    assign answer_name = (phase_reg == PH_ALEN) || (phase_reg == PH_ALABEL) ||
                         (phase_reg == PH_APTR);

    always_comb begin
        phase_next     = phase_reg;
        outcome_next   = outcome_reg;
        bif_next       = bif_reg;
        header_next    = header_reg;
        answers_next   = answers_reg;
        lbl_left_next  = lbl_left_reg;
        lbl_count_next = lbl_count_reg;
        rec_left_next  = rec_left_reg;
        fixed_next     = fixed_reg;
        addr_next      = addr_reg;

        if (outcome_reg == OUT_UNDECIDED) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (bif_reg == 4'd0 && word.src_port != cfg.server_port) begin
                        outcome_next = OUT_REJECT;
                    end else begin
                        if (bif_reg < HDR_KEEP_BYTES) begin
                            header_next = {header_reg[55:0], b};
                        end
                        bif_next = bif_reg + 4'd1;
                        if (bif_next == HDR_BYTES) begin
                            if (hdr_id != cfg.expected_query_id ||
                                (hdr_flags & FLAG_RESPONSE) == 16'd0 ||
                                (hdr_flags & FLAG_RCODE) != 16'd0 ||
                                hdr_qd != QDCOUNT_ONE) begin
                                outcome_next = OUT_REJECT;
                            end else begin
                                answers_next   = header_reg[15:0];
                                phase_next     = PH_QLEN;
                                lbl_count_next = 8'd0;
                                bif_next       = 4'd0;
                            end
                        end
                    end
                end
                PH_QLEN, PH_ALEN: begin
                    if (b == 8'd0) begin
                        bif_next = 4'd0;
                        if (answer_name) begin
                            phase_next = PH_AFIXED;
                            fixed_next = 48'd0;
                        end else begin
                            phase_next = PH_QFIXED;
                        end
                    end else if ((b & LEN_PTR_MASK) == LEN_PTR_MASK) begin
                        phase_next = answer_name ? PH_APTR : PH_QPTR;
                    end else if (b > LABEL_MAX || lbl_count_reg >= LABEL_LIMIT_B) begin
                        outcome_next = OUT_REJECT;
                    end else begin
                        lbl_count_next = lbl_count_reg + 8'd1;
                        lbl_left_next  = b[5:0];
                        phase_next     = answer_name ? PH_ALABEL : PH_QLABEL;
                    end
                end
                PH_QLABEL, PH_ALABEL: begin
                    lbl_left_next = lbl_left_reg - 6'd1;
                    if (lbl_left_next == 6'd0) begin
                        phase_next = answer_name ? PH_ALEN : PH_QLEN;
                    end
                end
                PH_QPTR: begin
                    bif_next   = 4'd0;
                    phase_next = PH_QFIXED;
                end
                PH_APTR: begin
                    bif_next   = 4'd0;
                    phase_next = PH_AFIXED;
                    fixed_next = 48'd0;
                end
                PH_QFIXED: begin
                    bif_next = bif_reg + 4'd1;
                    if (bif_next == QFIXED_BYTES) begin
                        bif_next = 4'd0;
                        if (answers_reg == 16'd0) begin
                            outcome_next = OUT_NOADDR;
                        end else begin
                            phase_next     = PH_ALEN;
                            lbl_count_next = 8'd0;
                        end
                    end
                end
                PH_AFIXED: begin
                    if (bif_reg < TTL_FIRST || bif_reg >= TTL_END) begin
                        fixed_next = {fixed_reg[39:0], b};
                    end
                    bif_next = bif_reg + 4'd1;
                    if (bif_next == AFIXED_BYTES) begin
                        bif_next      = 4'd0;
                        rec_left_next = fixed_next[15:0];
                        if (fixed_next[47:32] == TYPE_A && fixed_next[31:16] == CLASS_IN &&
                            fixed_next[15:0] == A_RDLENGTH) begin
                            phase_next = PH_RADDR;
                            addr_next  = 32'd0;
                        end else if (fixed_next[15:0] == 16'd0) begin
                            answers_next = ans_dec;
                            if (ans_dec == 16'd0) begin
                                outcome_next = OUT_NOADDR;
                            end else begin
                                phase_next     = PH_ALEN;
                                lbl_count_next = 8'd0;
                            end
                        end else begin
                            phase_next = PH_RSKIP;
                        end
                    end
                end
                PH_RSKIP: begin
                    rec_left_next = rec_left_reg - 16'd1;
                    if (rec_left_next == 16'd0) begin
                        answers_next = ans_dec;
                        if (ans_dec == 16'd0) begin
                            outcome_next = OUT_NOADDR;
                        end else begin
                            phase_next     = PH_ALEN;
                            lbl_count_next = 8'd0;
                        end
                    end
                end
                PH_RADDR: begin
                    addr_next     = {addr_reg[23:0], b};
                    rec_left_next = rec_left_reg - 16'd1;
                    if (rec_left_next == 16'd0) begin
                        outcome_next = OUT_FOUND;
                    end
                end
                default: begin
                    outcome_next = OUT_REJECT;
                end
            endcase
        end

        outcome_final = (outcome_next == OUT_UNDECIDED) ? OUT_REJECT : outcome_next;
        res.status    = outcome_final;
        res.address   = (outcome_final == OUT_FOUND) ? addr_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || res_valid) begin
            phase_reg     <= PH_HEADER;
            outcome_reg   <= OUT_UNDECIDED;
            bif_reg       <= 4'd0;
            header_reg    <= 64'd0;
            answers_reg   <= 16'd0;
            lbl_left_reg  <= 6'd0;
            lbl_count_reg <= 8'd0;
            rec_left_reg  <= 16'd0;
            fixed_reg     <= 48'd0;
            addr_reg      <= 32'd0;
        end else if (take) begin
            phase_reg     <= phase_next;
            outcome_reg   <= outcome_next;
            bif_reg       <= bif_next;
            header_reg    <= header_next;
            answers_reg   <= answers_next;
            lbl_left_reg  <= lbl_left_next;
            lbl_count_reg <= lbl_count_next;
            rec_left_reg  <= rec_left_next;
            fixed_reg     <= fixed_next;
            addr_reg      <= addr_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (phase_reg == PH_HEADER && outcome_reg == OUT_UNDECIDED))
        else $error("parse state not cleared after result");

    a_decided_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (outcome_reg != OUT_UNDECIDED && !res_valid) |=> $stable(outcome_reg))
        else $error("decided outcome changed before last word");

    a_status_decided: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res.status != OUT_UNDECIDED)
        else $error("result issued without a decision");

    a_address_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != OUT_FOUND) |-> res.address == 32'd0)
        else $error("address reported without a found status");

    a_take_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> word_valid)
        else $error("word consumed while input stage empty");
`endif

endmodule

@@ src/dnsp_out_stage.sv @@
// Result register driving the output channel.
`timescale 1ns / 1ps

module dnsp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  dnsp_pkg::result_t res,
    output logic             out_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_address
);
    import dnsp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_status  = res_reg.status;
    assign m_address = res_reg.address;

    always_comb begin
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the DNS A-record response parser.
`timescale 1ns / 1ps

module testbench;

    import dnsp_pkg::*;

    localparam int PERIOD       = 8;
    localparam int RESET_CYCLES = 11;
    localparam int WATCHDOG     = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_WORDS = 120;
    localparam int IDLE_PCT     = 37;
    localparam int MAX_LABELS   = 128;

    localparam logic [15:0] QR_FLAG       = 16'h8000;
    localparam logic [15:0] RCODE_MASK    = 16'h000F;
    localparam logic [15:0] REPLY_FLAGS   = 16'h8180;
    localparam logic [7:0]  PTR_MARK      = 8'hC0;
    localparam logic [7:0]  MAX_LABEL_LEN = 8'd63;
    localparam logic [15:0] RR_TYPE_A     = 16'd1;
    localparam logic [15:0] RR_CLASS_IN   = 16'd1;
    localparam logic [15:0] A_DATA_LEN    = 16'd4;

    typedef enum logic [3:0] {
        ST_HEADER, ST_QLEN, ST_QLABEL, ST_QPTR, ST_QFIXED,
        ST_ALEN, ST_ALABEL, ST_APTR, ST_AFIXED, ST_RSKIP, ST_RADDR
    } parse_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic [15:0] s_src_port = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_address;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = REG_QUERY_ID;
    logic [15:0] cfg_wr_data = '0;

    dns_response_a_record_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_src_port  (s_src_port),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_address   (m_address),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    logic [15:0]  want_query_id;
    logic [15:0]  want_port;
    parse_state_t dp_state;
    logic [3:0]   dp_pos;
    logic [63:0]  dp_header;
    logic [15:0]  dp_answers;
    logic [5:0]   dp_label_left;
    logic [7:0]   dp_labels;
    logic [15:0]  dp_rdata_left;
    logic [47:0]  dp_rr_fields;
    logic [31:0]  dp_address;
    outcome_t     dp_outcome;

    result_t     expected_verdicts[$];
    logic [7:0]  pkt[$];
    int          failures = 0;
    int          words_sent = 0;
    int          idle_pct = IDLE_PCT;
    int          sink_hold = 0;
    int          stall_cycles = 0;

    function automatic void clear_packet();
        dp_state = ST_HEADER;
        dp_pos = '0;
        dp_header = '0;
        dp_answers = '0;
        dp_label_left = '0;
        dp_labels = '0;
        dp_rdata_left = '0;
        dp_rr_fields = '0;
        dp_address = '0;
        dp_outcome = OUT_UNDECIDED;
    endfunction

    function automatic void begin_answer_name();
        dp_state = ST_ALEN;
        dp_labels = '0;
    endfunction

    function automatic void advance_answer();
        dp_answers = dp_answers - 16'd1;
        if (dp_answers == 0) begin
            dp_outcome = OUT_NOADDR;
        end else begin
            begin_answer_name();
        end
    endfunction

    function automatic void finish_name(input bit answer);
        dp_pos = '0;
        if (answer) begin
            dp_state = ST_AFIXED;
            dp_rr_fields = '0;
        end else begin
            dp_state = ST_QFIXED;
        end
    endfunction

    function automatic void step_name(input logic [7:0] b, input bit answer);
        if (dp_state == ST_QLEN || dp_state == ST_ALEN) begin
            if (b == 0) begin
                finish_name(answer);
            end else if ((b & PTR_MARK) == PTR_MARK) begin
                dp_state = answer ? ST_APTR : ST_QPTR;
            end else if (b > MAX_LABEL_LEN || dp_labels >= MAX_LABELS) begin
                dp_outcome = OUT_REJECT;
            end else begin
                dp_labels = dp_labels + 8'd1;
                dp_label_left = b[5:0];
                dp_state = answer ? ST_ALABEL : ST_QLABEL;
            end
        end else if (dp_state == ST_QLABEL || dp_state == ST_ALABEL) begin
            dp_label_left = dp_label_left - 6'd1;
            if (dp_label_left == 0) begin
                dp_state = answer ? ST_ALEN : ST_QLEN;
            end
        end else begin
            finish_name(answer);
        end
    endfunction

    function automatic void step_parser(input logic [7:0] b, input logic [15:0] port);
        logic [15:0] flags;
        logic [15:0] rr_type;
        logic [15:0] rr_class;
        logic [15:0] rr_len;
        case (dp_state)
            ST_HEADER: begin
                if (dp_pos == 0 && port != want_port) begin
                    dp_outcome = OUT_REJECT;
                end else begin
                    if (dp_pos < 8) begin
                        dp_header = {dp_header[55:0], b};
                    end
                    dp_pos = dp_pos + 4'd1;
                    if (dp_pos == 12) begin
                        flags = dp_header[47:32];
                        if (dp_header[63:48] != want_query_id || (flags & QR_FLAG) == 0 ||
                            (flags & RCODE_MASK) != 0 || dp_header[31:16] != 16'd1) begin
                            dp_outcome = OUT_REJECT;
                        end else begin
                            dp_answers = dp_header[15:0];
                            dp_state = ST_QLEN;
                            dp_labels = '0;
                            dp_pos = '0;
                        end
                    end
                end
            end
            ST_QLEN, ST_QLABEL, ST_QPTR: step_name(b, 1'b0);
            ST_QFIXED: begin
                dp_pos = dp_pos + 4'd1;
                if (dp_pos == 4) begin
                    dp_pos = '0;
                    if (dp_answers == 0) begin
                        dp_outcome = OUT_NOADDR;
                    end else begin
                        begin_answer_name();
                    end
                end
            end
            ST_ALEN, ST_ALABEL, ST_APTR: step_name(b, 1'b1);
            ST_AFIXED: begin
                if (dp_pos < 4 || dp_pos >= 8) begin
                    dp_rr_fields = {dp_rr_fields[39:0], b};
                end
                dp_pos = dp_pos + 4'd1;
                if (dp_pos == 10) begin
                    rr_type = dp_rr_fields[47:32];
                    rr_class = dp_rr_fields[31:16];
                    rr_len = dp_rr_fields[15:0];
                    dp_pos = '0;
                    dp_rdata_left = rr_len;
                    if (rr_type == RR_TYPE_A && rr_class == RR_CLASS_IN && rr_len == A_DATA_LEN) begin
                        dp_state = ST_RADDR;
                        dp_address = '0;
                    end else if (rr_len == 0) begin
                        advance_answer();
                    end else begin
                        dp_state = ST_RSKIP;
                    end
                end
            end
            ST_RSKIP: begin
                dp_rdata_left = dp_rdata_left - 16'd1;
                if (dp_rdata_left == 0) begin
                    advance_answer();
                end
            end
            ST_RADDR: begin
                dp_address = {dp_address[23:0], b};
                dp_rdata_left = dp_rdata_left - 16'd1;
                if (dp_rdata_left == 0) begin
                    dp_outcome = OUT_FOUND;
                end
            end
            default: dp_outcome = OUT_REJECT;
        endcase
    endfunction

    function automatic void parse_dns_byte(input logic [7:0] b, input logic [15:0] port,
                                           input logic last);
        result_t verdict;
        if (dp_outcome == OUT_UNDECIDED) begin
            step_parser(b, port);
        end
        if (last) begin
            if (dp_outcome == OUT_UNDECIDED) begin
                dp_outcome = OUT_REJECT;
            end
            verdict.status = dp_outcome;
            verdict.address = (dp_outcome == OUT_FOUND) ? dp_address : 32'd0;
            expected_verdicts.push_back(verdict);
            clear_packet();
        end
    endfunction

    function automatic void put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_label(input int len);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_name(input int n_labels, input bit use_ptr);
        repeat (n_labels) put_label($urandom_range(1, 6));
        if (use_ptr) begin
            pkt.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
            pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(8'h00);
        end
    endfunction

    function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                       input logic [15:0] qd, input logic [15:0] an);
        pkt.delete();
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void start_reply(input logic [15:0] an);
        put_header(want_query_id, REPLY_FLAGS, 16'd1, an);
    endfunction

    function automatic void put_question();
        put_name($urandom_range(0, 2), $urandom_range(0, 3) == 0);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void put_rr_head(input logic [15:0] rr_type, input logic [15:0] rr_class,
                                        input logic [15:0] rr_len);
        put_name($urandom_range(0, 2), $urandom_range(0, 1) == 1);
        put16(rr_type);
        put16(rr_class);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(rr_len);
    endfunction

    function automatic void put_other_record(input logic [15:0] rr_type,
                                             input logic [15:0] rr_class, input int len);
        put_rr_head(rr_type, rr_class, 16'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_a_record(input logic [31:0] addr);
        put_rr_head(RR_TYPE_A, RR_CLASS_IN, A_DATA_LEN);
        put16(addr[31:16]);
        put16(addr[15:0]);
    endfunction

    function automatic void cut_packet(input int len);
        pkt = pkt[0:len - 1];
    endfunction

    task automatic send_word(input logic [7:0] b, input logic [15:0] port, input logic last);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_src_port <= port;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_dns_byte(b, port, last);
        words_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_packet(input logic [15:0] first_port);
        for (int i = 0; i < pkt.size(); i++) begin
            send_word(pkt[i], (i == 0) ? first_port : 16'($urandom), i == pkt.size() - 1);
        end
    endtask

    task automatic send_reply();
        send_packet(want_port);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx == REG_QUERY_ID) begin
            want_query_id = val;
        end else begin
            want_port = val;
        end
    endtask

    task automatic set_config(input logic [15:0] id, input logic [15:0] port);
        write_reg(REG_QUERY_ID, id);
        write_reg(REG_SERVER_PORT, port);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic build_random_packet();
        int kind;
        logic [15:0] id;
        logic [15:0] flags;
        logic [15:0] qd;
        int an;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        end else begin
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : want_query_id;
            flags = QR_FLAG | (16'($urandom) & 16'h7FF0);
            if ($urandom_range(0, 9) == 0) begin
                flags = 16'($urandom);
            end
            qd = ($urandom_range(0, 14) == 0) ? 16'($urandom_range(0, 3)) : 16'd1;
            an = $urandom_range(0, 3);
            put_header(id, flags, qd, 16'(an));
            put_question();
            repeat (an) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    put_a_record(32'($urandom));
                end else if (pick < 6) begin
                    put_other_record(RR_TYPE_A, RR_CLASS_IN, $urandom_range(0, 6));
                end else begin
                    put_other_record(16'($urandom_range(0, 40)), 16'($urandom_range(0, 3)),
                                     $urandom_range(0, 6));
                end
            end
            if (kind < 22) begin
                pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
            end else if (kind < 30) begin
                cut_packet($urandom_range(1, pkt.size()));
            end else if (kind < 38) begin
                repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
            end
        end
    endtask

    task automatic test_found_address();
        start_reply(16'd1);
        put_question();
        put_a_record(32'hFFFF_FFFF);
        send_reply();
        start_reply(16'd1);
        put_question();
        put_a_record(32'h0000_0000);
        repeat (6) pkt.push_back(8'hFF);
        send_reply();
        wait_drain();
    endtask

    task automatic test_header_checks();
        start_reply(16'd1);
        put_question();
        put_a_record(32'($urandom));
        send_packet(want_port ^ 16'hFFFF);
        put_header(want_query_id ^ 16'h0001, REPLY_FLAGS, 16'd1, 16'd0);
        put_question();
        send_reply();
        put_header(want_query_id, REPLY_FLAGS & ~QR_FLAG, 16'd1, 16'd0);
        put_question();
        send_reply();
        put_header(want_query_id, REPLY_FLAGS | 16'h0003, 16'd1, 16'd0);
        put_question();
        send_reply();
        put_header(want_query_id, REPLY_FLAGS, 16'd0, 16'd0);
        send_reply();
        put_header(want_query_id, REPLY_FLAGS, 16'd2, 16'd0);
        put_question();
        put_question();
        send_reply();
        pkt.delete();
        pkt.push_back(8'hFF);
        send_reply();
        start_reply(16'd0);
        cut_packet(7);
        send_reply();
        wait_drain();
    endtask

    task automatic test_names();
        start_reply(16'd0);
        pkt.push_back(PTR_MARK);
        pkt.push_back(8'h0C);
        put16(16'($urandom));
        put16(16'($urandom));
        send_reply();
        start_reply(16'd0);
        put_label(MAX_LABEL_LEN);
        pkt.push_back(8'h00);
        put16(16'($urandom));
        put16(16'($urandom));
        send_reply();
        start_reply(16'd0);
        pkt.push_back(MAX_LABEL_LEN + 8'd1);
        repeat (4) pkt.push_back(8'($urandom));
        send_reply();
        start_reply(16'd0);
        pkt.push_back(PTR_MARK - 8'd1);
        pkt.push_back(8'h00);
        send_reply();
        start_reply(16'd1);
        repeat (MAX_LABELS) put_label(1);
        pkt.push_back(8'h00);
        put16(16'($urandom));
        put16(16'($urandom));
        put_a_record(32'($urandom));
        send_reply();
        start_reply(16'd0);
        repeat (MAX_LABELS + 1) put_label(1);
        pkt.push_back(8'h00);
        send_reply();
        start_reply(16'd0);
        put_label(3);
        cut_packet(pkt.size() - 1);
        send_reply();
        wait_drain();
    endtask

    task automatic test_records();
        start_reply(16'd0);
        put_question();
        send_reply();
        start_reply(16'd2);
        put_question();
        put_other_record(16'd5, RR_CLASS_IN, 3);
        put_a_record(32'($urandom));
        send_reply();
        start_reply(16'd2);
        put_question();
        put_other_record(16'd16, RR_CLASS_IN, 0);
        put_a_record(32'($urandom));
        send_reply();
        start_reply(16'd1);
        put_question();
        put_other_record(RR_TYPE_A, RR_CLASS_IN, 5);
        send_reply();
        start_reply(16'd1);
        put_question();
        put_other_record(RR_TYPE_A, 16'd3, 4);
        send_reply();
        start_reply(16'd1);
        put_question();
        put_a_record(32'($urandom));
        cut_packet(pkt.size() - 2);
        send_reply();
        start_reply(16'hFFFF);
        put_question();
        put_other_record(16'd28, RR_CLASS_IN, 2);
        send_reply();
        wait_drain();
    endtask

    task automatic probe_config();
        start_reply(16'd1);
        put_question();
        put_a_record(32'($urandom));
        send_reply();
        put_header(want_query_id + 16'd1, REPLY_FLAGS, 16'd1, 16'd0);
        put_question();
        send_reply();
        start_reply(16'd0);
        put_question();
        send_packet(want_port - 16'd1);
        wait_drain();
    endtask

    task automatic test_config();
        probe_config();
        set_config(16'h0000, 16'h0000);
        probe_config();
        set_config(16'hFFFF, 16'hFFFF);
        probe_config();
    endtask

    task automatic test_streaming();
        idle_pct = 0;
        repeat (3) begin
            build_random_packet();
            send_reply();
        end
        wait_drain();
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_backpressure();
        sink_hold = 400;
        repeat (6) begin
            if ($urandom_range(0, 1)) begin
                pkt.delete();
                pkt.push_back(8'($urandom));
            end else begin
                start_reply(16'd1);
                put_question();
                put_a_record(32'($urandom));
            end
            send_reply();
        end
        wait_drain();
    endtask

    task automatic test_random();
        int round_words;
        for (int round = 0; round < 4; round++) begin
            set_config(16'($urandom), 16'($urandom));
            round_words = words_sent + RANDOM_WORDS / 4;
            while (words_sent < round_words) begin
                build_random_packet();
                send_packet(($urandom_range(0, 19) == 0) ? 16'($urandom) : want_port);
            end
            wait_drain();
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_verdicts
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected result word: status %0d, address %h", m_status, m_address);
                failures++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
                if (m_address !== want.address) begin
                    $error("address: expected %h, got %h", want.address, m_address);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        want_query_id = QUERY_ID_RESET;
        want_port = SERVER_PORT_RESET;
        clear_packet();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_found_address();
        test_header_checks();
        test_names();
        test_records();
        test_config();
        test_streaming();
        test_backpressure();
        test_random();
        wait_drain();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
